// ----- rtl/tsn_pkg.sv -----
// ----------------------------------------------------------------------------
// tsn_pkg - shared types and constants of the text space normalizer
// Holds the result word that travels from the front end through the queue
// to the back end, the queue status and the queue sizing.
// ----------------------------------------------------------------------------
package tsn_pkg;

    // One input byte gives at most four bytes: a flushed group of three
    // buffered bytes plus the closing byte.
    localparam int MaxSlots   = 4;
    localparam int SlotIdxW   = $clog2(MaxSlots);
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [7:0] SpaceByte = 8'h20;

    typedef struct packed {
        logic [MaxSlots-1:0][7:0] bytes;   // result bytes, slot 0 first
        logic [SlotIdxW-1:0]      top;     // index of the final slot used
        logic                     is_data; // 0 for the bare end marker
        logic                     last;    // word closes the text
    } tsn_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tsn_qstat_t;

endpackage

// ----- rtl/tsn_front.sv -----
// ----------------------------------------------------------------------------
// tsn_front - byte classifier and word builder
// Takes one input byte per cycle while the queue is not full, tracks blank runs,
// punctuation and UTF-8 groups, and builds the word of result bytes that the byte releases.
// ----------------------------------------------------------------------------
module tsn_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  tsn_pkg::tsn_qstat_t qstat,
    output logic               push,
    output tsn_pkg::tsn_word_t push_word
);

    logic       space_pending_reg, space_pending_next;
    logic       started_reg, started_next;
    logic [7:0] last_emitted_reg, last_emitted_next;
    logic       prev_stop_reg, prev_stop_next;
    logic [1:0] remaining_reg, remaining_next;
    logic [1:0] filled_reg, filled_next;
    logic [7:0] group_reg [0:2];
    logic [7:0] group_next [0:2];

    logic       accept;
    logic [2:0] n_out;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b == 8'h2C) || (b == 8'h2E) || (b == 8'h3F) || (b == 8'h21) ||
               (b == 8'h3A) || (b == 8'h3B);
    endfunction

    assign src_stall = qstat.full;
    assign accept    = src_valid && !qstat.full;

    always_comb
    begin
        logic is_stop;
        logic sp_emit;
        logic emit_b;

        space_pending_next = space_pending_reg;
        started_next       = started_reg;
        last_emitted_next  = last_emitted_reg;
        prev_stop_next     = prev_stop_reg;
        remaining_next     = remaining_reg;
        filled_next        = filled_reg;
        for (int j = 0; j < 3; j++)
        begin
            group_next[j] = group_reg[j];
        end
        push_word         = '0;
        push_word.is_data = 1'b1;
        push_word.last    = in_last;
        n_out             = '0;
        is_stop           = 1'b0;
        sp_emit           = 1'b0;
        emit_b            = 1'b0;

        if (remaining_reg != 2'd0)
        begin
            // inside a group: slots are the buffered bytes, then this byte
            for (int i = 0; i < 3; i++)
            begin
                push_word.bytes[i] = (2'(i) < filled_reg) ? group_reg[i] : in_byte;
            end
            push_word.bytes[tsn_pkg::MaxSlots-1] = in_byte;
            n_out = {1'b0, filled_reg} + 3'd1;

            if (remaining_reg == 2'd1)
            begin
                is_stop = (filled_reg == 2'd2) && (group_reg[0] == 8'hE3) &&
                          (group_reg[1] == 8'h80) && (in_byte == 8'h82);
                if (is_stop && prev_stop_reg)
                begin
                    // drop a repeated full-width full stop
                    n_out = '0;
                end
                else
                begin
                    last_emitted_next = in_byte;
                    started_next      = 1'b1;
                    prev_stop_next    = is_stop;
                end
                remaining_next = '0;
                filled_next    = '0;
            end
            else if (!in_last)
            begin
                n_out = '0;
                for (int j = 0; j < 3; j++)
                begin
                    if (filled_reg == 2'(j))
                    begin
                        group_next[j] = in_byte;
                    end
                end
                filled_next    = filled_reg + 2'd1;
                remaining_next = remaining_reg - 2'd1;
            end
        end
        else if (!in_byte[7] && is_blank(in_byte))
        begin
            space_pending_next = 1'b1;
        end
        else
        begin
            sp_emit = space_pending_reg && started_reg && !is_punct(last_emitted_reg) &&
                      (in_byte[7] || !is_punct(in_byte));
            space_pending_next = 1'b0;
            if (!in_byte[7])
            begin
                emit_b = sp_emit || !(started_reg && (in_byte == last_emitted_reg) &&
                                      is_punct(in_byte));
            end
            else
            begin
                emit_b = in_last;
                if (!in_last)
                begin
                    group_next[0] = in_byte;
                    filled_next   = 2'd1;
                    if (in_byte[7:5] == 3'b110)
                    begin
                        remaining_next = 2'd1;
                    end
                    else if (in_byte[7:4] == 4'b1110)
                    begin
                        remaining_next = 2'd2;
                    end
                    else
                    begin
                        remaining_next = 2'd3;
                    end
                end
            end
            push_word.bytes[0] = sp_emit ? tsn_pkg::SpaceByte : in_byte;
            push_word.bytes[1] = in_byte;
            n_out = {2'b00, sp_emit} + {2'b00, emit_b};
            if (emit_b)
            begin
                last_emitted_next = in_byte;
                started_next      = 1'b1;
                prev_stop_next    = 1'b0;
            end
            else if (sp_emit)
            begin
                last_emitted_next = tsn_pkg::SpaceByte;
                started_next      = 1'b1;
                prev_stop_next    = 1'b0;
            end
        end

        if (in_last)
        begin
            if (n_out == 3'd0)
            begin
                // nothing to show: send the bare end marker
                push_word.bytes[0] = '0;
                push_word.is_data  = 1'b0;
                n_out              = 3'd1;
            end
            space_pending_next = 1'b0;
            started_next       = 1'b0;
            last_emitted_next  = '0;
            prev_stop_next     = 1'b0;
            remaining_next     = '0;
            filled_next        = '0;
        end

        push_word.top = tsn_pkg::SlotIdxW'(n_out - 3'd1);
    end

    assign push = accept && (n_out != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_pending_reg <= 1'b0;
            started_reg       <= 1'b0;
            last_emitted_reg  <= '0;
            prev_stop_reg     <= 1'b0;
            remaining_reg     <= '0;
            filled_reg        <= '0;
        end
        else if (accept)
        begin
            space_pending_reg <= space_pending_next;
            started_reg       <= started_next;
            last_emitted_reg  <= last_emitted_next;
            prev_stop_reg     <= prev_stop_next;
            remaining_reg     <= remaining_next;
            filled_reg        <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < 3; j++)
            begin
                group_reg[j] <= group_next[j];
            end
        end
    end

endmodule

// ----- rtl/tsn_queue.sv -----
// ----------------------------------------------------------------------------
// tsn_queue - word queue between front end and back end
// Small register queue that lets the front end run ahead of the output.
// ----------------------------------------------------------------------------
module tsn_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tsn_pkg::tsn_word_t  push_word,
    input  logic                pop,
    output tsn_pkg::tsn_word_t  head,
    output tsn_pkg::tsn_qstat_t qstat
);

    tsn_pkg::tsn_word_t              store_reg [0:tsn_pkg::QueueDepth-1];
    logic [tsn_pkg::QueuePtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tsn_pkg::QueuePtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tsn_pkg::QueueCntW-1:0]   count_reg, count_next;
    logic                            do_push, do_pop;

    assign qstat.full  = (count_reg == tsn_pkg::QueueCntW'(tsn_pkg::QueueDepth));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- rtl/tsn_back.sv -----
// ----------------------------------------------------------------------------
// tsn_back - word serializer and output register
// Walks the slots of the head word and sends one byte per cycle, while dst_stall
// does not hold the output, through a registered output stage.
// ----------------------------------------------------------------------------
module tsn_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  tsn_pkg::tsn_word_t  head,
    input  tsn_pkg::tsn_qstat_t qstat,
    output logic                pop,
    output logic                dst_valid,
    input  logic                dst_stall,
    output logic [7:0]          out_byte,
    output logic                out_valid,
    output logic                out_last
);

    logic                          dv_reg, dv_next;
    logic [7:0]                    byte_reg, byte_next;
    logic                          flag_reg, flag_next;
    logic                          last_reg, last_next;
    logic [tsn_pkg::SlotIdxW-1:0]  idx_reg, idx_next;
    logic                          load;
    logic                          at_top;

    // output stage is free or being taken this cycle
    assign load   = !dv_reg || !dst_stall;
    assign at_top = (idx_reg == head.top);
    assign pop    = load && !qstat.empty && at_top;

    always_comb
    begin
        dv_next   = dv_reg;
        byte_next = byte_reg;
        flag_next = flag_reg;
        last_next = last_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            dv_next = !qstat.empty;
            if (!qstat.empty)
            begin
                byte_next = head.bytes[idx_reg];
                flag_next = head.is_data;
                last_next = head.last && at_top;
                idx_next  = at_top ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg  <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            dv_reg  <= dv_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        flag_reg <= flag_next;
        last_reg <= last_next;
    end

    assign dst_valid = dv_reg;
    assign out_byte  = byte_reg;
    assign out_valid = flag_reg;
    assign out_last  = last_reg;

endmodule

// ----- rtl/utf8_text_space_normalizer.sv -----
// ----------------------------------------------------------------------------
// utf8_text_space_normalizer - UTF-8 text space normalizer
// Collapses blank runs, drops repeated punctuation and copies UTF-8 groups
// whole, one input byte per cycle while src_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel src_valid/src_stall carries in_byte and in_last; a word is
//   taken on a rising edge with src_valid high and src_stall low. The final
//   byte of a text carries in_last; state then returns to its reset value.
//   Output channel dst_valid/dst_stall carries out_byte, out_valid and
//   out_last. out_valid low marks a bare end marker (text produced nothing).
//   out_last is set on the final output word of each text.
//   Throughput: one input byte per cycle while src_stall is low. Each input
//   byte releases zero to four output bytes; the output side sends one byte
//   per cycle while dst_stall is low, so the output port is the limit when a
//   multi-byte group is flushed. An accepted byte's word is written into a
//   four-word queue, and the output register then takes its first byte.
//   src_stall rises only while that queue is full; a stalled output holds
//   its word and lets the queue fill. Reset clears all control state and
//   empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_text_space_normalizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       dst_valid,
    input  logic       dst_stall,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       out_last
);

    tsn_pkg::tsn_qstat_t qstat;
    tsn_pkg::tsn_word_t  push_word;
    tsn_pkg::tsn_word_t  head;
    logic                push;
    logic                pop;

    tsn_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .qstat     (qstat),
        .push      (push),
        .push_word (push_word)
    );

    tsn_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    tsn_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .out_last  (out_last)
    );

endmodule
